// ===== design/inductive_position_from_counts_core_assert.svh =====
// assertion helpers used by the position core back end
`ifndef INDUCTIVE_POSITION_FROM_COUNTS_CORE_ASSERT_SVH
`define INDUCTIVE_POSITION_FROM_COUNTS_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define IPC_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipc check failed");

// next-cycle implication, held off during reset
`define IPC_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipc check failed");

`endif

// ===== design/ipc_pkg.sv =====
package ipc_pkg;
  localparam int AVG_WINDOW_DEF = 10;
  localparam int CAL_POINTS = 26;
  localparam int FREQ_FRAC_BITS = 4;
  localparam int POS_FRAC_BITS = 8;
  localparam int CNT_W = 28;
  localparam int FREQ_W = 30;
  localparam int REFCLK_W = 26;
  localparam int POS_W = 15;
  localparam int HW = 8 + POS_FRAC_BITS;
  localparam int CIDX_W = $clog2(CAL_POINTS);
  localparam int DIV_W = FREQ_W + HW + 2;
  localparam int QUO_W = FREQ_W;
  localparam int QIDX_W = $clog2(QUO_W);
  localparam int STEP_W = $clog2(QUO_W + 1);
  localparam int PROD_W = CNT_W + REFCLK_W;
  localparam int FREQ_SHIFT = 28 - FREQ_FRAC_BITS;
  localparam int HALF_CNT = CNT_W / 2;

  localparam logic [REFCLK_W-1:0] REFCLK_RST = 26'd43400000;
  localparam logic [FREQ_W-1:0] LIMIT_RST = 30'd74400000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic REG_REFCLK = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [3:0] flags;
    logic all_zero;
    logic all_ones;
    logic [CNT_W-1:0] count;
  } ipc_item_t;

  typedef struct packed {
    logic start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } ipc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [QUO_W-1:0] quo;
  } ipc_div_rsp_t;

  // calibration frequency in hz, scaled to the frequency fraction
  function automatic logic [FREQ_W-1:0] cal_freq(input logic [CIDX_W-1:0] idx);
    logic [22:0] hz;
    unique case (idx)
      5'd0: hz = 23'd4384660;
      5'd1: hz = 23'd4387270;
      5'd2: hz = 23'd4394020;
      5'd3: hz = 23'd4403530;
      5'd4: hz = 23'd4409910;
      5'd5: hz = 23'd4414720;
      5'd6: hz = 23'd4425420;
      5'd7: hz = 23'd4427930;
      5'd8: hz = 23'd4439230;
      5'd9: hz = 23'd4450700;
      5'd10: hz = 23'd4455930;
      5'd11: hz = 23'd4469240;
      5'd12: hz = 23'd4474700;
      5'd13: hz = 23'd4483830;
      5'd14: hz = 23'd4488520;
      5'd15: hz = 23'd4489510;
      5'd16: hz = 23'd4504090;
      5'd17: hz = 23'd4512420;
      5'd18: hz = 23'd4514030;
      5'd19: hz = 23'd4519350;
      5'd20: hz = 23'd4528860;
      5'd21: hz = 23'd4535550;
      5'd22: hz = 23'd4544030;
      5'd23: hz = 23'd4583900;
      5'd24: hz = 23'd4618950;
      5'd25: hz = 23'd4630000;
      default: hz = 23'd0;
    endcase
    return FREQ_W'(hz) << FREQ_FRAC_BITS;
  endfunction

  // calibration position in half millimetres, scaled to the position fraction
  function automatic logic [HW-1:0] cal_pos(input logic [CIDX_W-1:0] idx);
    logic [7:0] hm;
    unique case (idx)
      5'd0: hm = 8'd0;
      5'd1: hm = 8'd10;
      5'd2: hm = 8'd20;
      5'd3: hm = 8'd30;
      5'd4: hm = 8'd35;
      5'd5: hm = 8'd40;
      5'd6: hm = 8'd45;
      5'd7: hm = 8'd50;
      5'd8: hm = 8'd55;
      5'd9: hm = 8'd60;
      5'd10: hm = 8'd65;
      5'd11: hm = 8'd70;
      5'd12: hm = 8'd75;
      5'd13: hm = 8'd80;
      5'd14: hm = 8'd85;
      5'd15: hm = 8'd90;
      5'd16: hm = 8'd95;
      5'd17: hm = 8'd100;
      5'd18: hm = 8'd105;
      5'd19: hm = 8'd110;
      5'd20: hm = 8'd115;
      5'd21: hm = 8'd120;
      5'd22: hm = 8'd130;
      5'd23: hm = 8'd140;
      5'd24: hm = 8'd150;
      5'd25: hm = 8'd160;
      default: hm = 8'd0;
    endcase
    return HW'(hm) << POS_FRAC_BITS;
  endfunction
endpackage

// ===== design/ipc_front.sv =====
module ipc_front (
  input  logic [15:0]         in_data_high_word,
  input  logic [15:0]         in_data_low_word,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output ipc_pkg::ipc_item_t  q_item
);
  import ipc_pkg::*;

  logic [CNT_W-1:0] count;

  assign count = {in_data_high_word[11:0], in_data_low_word};
  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_item.flags = in_data_high_word[15:12];
    q_item.all_zero = (count == '0);
    q_item.all_ones = (count == '1);
    q_item.count = count;
  end
endmodule

// ===== design/ipc_fifo.sv =====
module ipc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ipc_pkg::ipc_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output ipc_pkg::ipc_item_t rd_item
);
  import ipc_pkg::*;

  ipc_item_t mem_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? !wp_r : wp_r;
    rp_nxt = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end
endmodule

// ===== design/ipc_div.sv =====
module ipc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipc_pkg::ipc_div_req_t req,
  output ipc_pkg::ipc_div_rsp_t rsp
);
  import ipc_pkg::*;

  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [STEP_W-1:0] bit_r, bit_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt, den_r, den_nxt, trial;
  logic [QUO_W-1:0] quo_r, quo_nxt;

  // one quotient bit a cycle, msb first
  assign trial = den_r << bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    quo_nxt = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt = req.num;
      den_nxt = req.den;
      bit_nxt = req.steps - 1'b1;
      quo_nxt = '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        quo_nxt[bit_r[QIDX_W-1:0]] = 1'b1;
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = quo_r;
endmodule

// ===== design/ipc_back.sv =====
module ipc_back #(
  parameter int AVG_WINDOW = ipc_pkg::AVG_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ipc_pkg::REFCLK_W-1:0]  refclk,
  input  logic [ipc_pkg::FREQ_W-1:0]    limit,
  input  logic                          q_not_empty,
  input  ipc_pkg::ipc_item_t            q_item,
  output logic                          q_pop,
  output ipc_pkg::ipc_div_req_t         div_req,
  input  ipc_pkg::ipc_div_rsp_t         div_rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_error_flags,
  output logic                          out_count_all_zero,
  output logic                          out_count_all_ones,
  output logic [ipc_pkg::FREQ_W-1:0]    out_average_frequency,
  output logic                          out_position_valid,
  output logic [ipc_pkg::POS_W-1:0]     out_position_mm
);
  import ipc_pkg::*;
  `include "inductive_position_from_counts_core_assert.svh"

  localparam int SLOT_W = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int FILL_W = $clog2(AVG_WINDOW + 1);
  localparam int SUM_W = FREQ_W + FILL_W;
  localparam int SHIFTED_W = PROD_W - FREQ_SHIFT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_STORE = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_AVG   = 4'd5;
  localparam logic [3:0] S_AVGW  = 4'd6;
  localparam logic [3:0] S_SRCH  = 4'd7;
  localparam logic [3:0] S_IMUL  = 4'd8;
  localparam logic [3:0] S_IDIV  = 4'd9;
  localparam logic [3:0] S_IDIVW = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] st_r, st_nxt;
  ipc_item_t item_r, item_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [FREQ_W-1:0] ring_r [AVG_WINDOW];
  logic [SLOT_W-1:0] slot_r, slot_nxt, idx_r, idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [FREQ_W-1:0] avg_r, avg_nxt, df_r, df_nxt, d_r, d_nxt;
  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  logic [HW-1:0] h1_r, h1_nxt, dh_r, dh_nxt;
  logic [FREQ_W+HW-1:0] rprod_r, rprod_nxt;
  logic valid_r, valid_nxt;
  logic [HW:0] pos_r, pos_nxt;
  logic ring_we;
  logic [SHIFTED_W-1:0] shifted;
  logic [FREQ_W-1:0] freq, f1, f2;
  logic [CIDX_W-1:0] cidx_p1;
  logic ov_r, ov_nxt;
  ipc_item_t oi_r, oi_nxt;
  logic [FREQ_W-1:0] oavg_r, oavg_nxt;
  logic ovld_r, ovld_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;

  assign shifted = SHIFTED_W'(acc_r >> FREQ_SHIFT);
  assign freq = (shifted > SHIFTED_W'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(shifted);
  assign cidx_p1 = cidx_r + 1'b1;
  assign f1 = cal_freq(cidx_r);
  assign f2 = cal_freq(cidx_p1);

  always_comb begin
    st_nxt = st_r;
    item_nxt = item_r;
    acc_nxt = acc_r;
    slot_nxt = slot_r;
    idx_nxt = idx_r;
    fill_nxt = fill_r;
    sum_nxt = sum_r;
    avg_nxt = avg_r;
    df_nxt = df_r;
    d_nxt = d_r;
    cidx_nxt = cidx_r;
    h1_nxt = h1_r;
    dh_nxt = dh_r;
    rprod_nxt = rprod_r;
    valid_nxt = valid_r;
    pos_nxt = pos_r;
    ring_we = 1'b0;
    q_pop = 1'b0;
    div_req = '0;
    ov_nxt = ov_r;
    oi_nxt = oi_r;
    oavg_nxt = oavg_r;
    ovld_nxt = ovld_r;
    opos_nxt = opos_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          item_nxt = q_item;
          st_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        acc_nxt = PROD_W'(item_r.count[HALF_CNT-1:0] * refclk);
        st_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt = acc_r + (PROD_W'(item_r.count[CNT_W-1:HALF_CNT] * refclk) << HALF_CNT);
        st_nxt = S_STORE;
      end
      S_STORE: begin
        ring_we = 1'b1;
        slot_nxt = (slot_r == SLOT_W'(AVG_WINDOW - 1)) ? '0 : slot_r + 1'b1;
        if (fill_r < FILL_W'(AVG_WINDOW)) begin
          fill_nxt = fill_r + 1'b1;
        end
        sum_nxt = '0;
        idx_nxt = '0;
        st_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt = sum_r + SUM_W'(ring_r[idx_r]);
        if (FILL_W'(idx_r) + 1'b1 == fill_r) begin
          st_nxt = S_AVG;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_AVG: begin
        div_req.start = 1'b1;
        div_req.steps = STEP_W'(QUO_W);
        div_req.num = DIV_W'(sum_r);
        div_req.den = DIV_W'(fill_r);
        st_nxt = S_AVGW;
      end
      S_AVGW: begin
        if (div_rsp.done) begin
          avg_nxt = div_rsp.quo;
          valid_nxt = 1'b0;
          pos_nxt = '0;
          cidx_nxt = '0;
          st_nxt = (div_rsp.quo >= limit) ? S_DONE : S_SRCH;
        end
      end
      S_SRCH: begin
        if (avg_r >= f1 && avg_r <= f2) begin
          d_nxt = f2 - f1;
          df_nxt = avg_r - f1;
          h1_nxt = cal_pos(cidx_r);
          dh_nxt = cal_pos(cidx_p1) - cal_pos(cidx_r);
          st_nxt = S_IMUL;
        end else if (cidx_r == CIDX_W'(CAL_POINTS - 2)) begin
          st_nxt = S_DONE;
        end else begin
          cidx_nxt = cidx_p1;
        end
      end
      S_IMUL: begin
        rprod_nxt = (FREQ_W + HW)'(df_r * dh_r);
        st_nxt = S_IDIV;
      end
      S_IDIV: begin
        // odd h1 adds half a step to the numerator
        div_req.start = 1'b1;
        div_req.steps = STEP_W'(HW);
        div_req.num = DIV_W'(rprod_r) + (h1_r[0] ? DIV_W'(d_r) : '0);
        div_req.den = DIV_W'(d_r) << 1;
        st_nxt = S_IDIVW;
      end
      S_IDIVW: begin
        if (div_rsp.done) begin
          valid_nxt = 1'b1;
          pos_nxt = (HW + 1)'(h1_r >> 1) + (HW + 1)'(div_rsp.quo[HW-1:0]);
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          oi_nxt = item_r;
          oavg_nxt = avg_r;
          ovld_nxt = valid_r;
          opos_nxt = POS_W'(pos_r);
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      slot_r <= '0;
      fill_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    avg_r <= avg_nxt;
    df_r <= df_nxt;
    d_r <= d_nxt;
    cidx_r <= cidx_nxt;
    h1_r <= h1_nxt;
    dh_r <= dh_nxt;
    rprod_r <= rprod_nxt;
    valid_r <= valid_nxt;
    pos_r <= pos_nxt;
    oi_r <= oi_nxt;
    oavg_r <= oavg_nxt;
    ovld_r <= ovld_nxt;
    opos_r <= opos_nxt;
    if (ring_we) begin
      ring_r[slot_r] <= freq;
    end
  end

  assign out_valid = ov_r;
  assign out_error_flags = oi_r.flags;
  assign out_count_all_zero = oi_r.all_zero;
  assign out_count_all_ones = oi_r.all_ones;
  assign out_average_frequency = oavg_r;
  assign out_position_valid = ovld_r;
  assign out_position_mm = opos_r;

  `IPC_IMPLIES(a_pos_zero_when_invalid, ov_r && !ovld_r, opos_r == '0)
  `IPC_IMPLIES(a_div_start_idle, div_req.start, !div_rsp.busy)
  `IPC_NEXT(a_fill_after_store, st_r == S_STORE, fill_r != '0)
endmodule

// ===== design/inductive_position_from_counts_core.sv =====
// flow: the back end works one item at a time; the mean sums the filled window
//   (1..10 entries), and the work is dominated by the shared shift-subtract divider
//   (30 steps for the mean, 16 for the interpolation) and the one-segment-per-cycle
//   table search up to the matched calibration segment
// reset: synchronous active-low rst_n clears the queue, window slot and fill count,
//   and loads the registers with reference clock 43400000 and limit 74400000
module inductive_position_from_counts_core #(
  parameter int AVG_WINDOW = ipc_pkg::AVG_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 in_data_high_word,
  input  logic [15:0]                 in_data_low_word,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_error_flags,
  output logic                        out_count_all_zero,
  output logic                        out_count_all_ones,
  output logic [ipc_pkg::FREQ_W-1:0]  out_average_frequency,
  output logic                        out_position_valid,
  output logic [ipc_pkg::POS_W-1:0]   out_position_mm,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ipc_pkg::*;

  logic [REFCLK_W-1:0] refclk_r;
  logic [FREQ_W-1:0] limit_r;
  logic reg_wr;
  logic q_full, q_push, q_pop, q_not_empty;
  ipc_item_t push_item, head_item;
  ipc_div_req_t div_req;
  ipc_div_rsp_t div_rsp;

  // register port: always ready, word index from paddr bit 2
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refclk_r <= REFCLK_RST;
      limit_r <= LIMIT_RST;
    end else if (reg_wr) begin
      if (paddr[2] == REG_REFCLK) begin
        refclk_r <= pwdata[REFCLK_W-1:0];
      end else begin
        limit_r <= pwdata[FREQ_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_r) : 32'(refclk_r);

  // front end: split flags and count, classify the count
  ipc_front u_front (
    .in_data_high_word (in_data_high_word),
    .in_data_low_word  (in_data_low_word),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  // two-entry queue lets the front keep taking items while the back works
  ipc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_item   (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_item   (head_item)
  );

  // shared shift-subtract divider for the mean and the interpolation
  ipc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back end: frequency scaling, window mean, table search, interpolation
  ipc_back #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .refclk                (refclk_r),
    .limit                 (limit_r),
    .q_not_empty           (q_not_empty),
    .q_item                (head_item),
    .q_pop                 (q_pop),
    .div_req               (div_req),
    .div_rsp               (div_rsp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_error_flags       (out_error_flags),
    .out_count_all_zero    (out_count_all_zero),
    .out_count_all_ones    (out_count_all_ones),
    .out_average_frequency (out_average_frequency),
    .out_position_valid    (out_position_valid),
    .out_position_mm       (out_position_mm)
  );
endmodule
